### rtl/tcme_pkg.sv
// Shared types and constants for the tour crossover, mutate and evaluate block.
`default_nettype none
package tcme_pkg;
  localparam int MAX_CITIES = 16;
  localparam int CITY_BITS = 4;
  localparam int POS_BITS = 5;
  localparam int DIST_BITS = 16;
  localparam int LEN_BITS = 20;
  localparam int DADDR_BITS = 2 * CITY_BITS;
  localparam int PADDR_BITS = CITY_BITS + 1;
  localparam logic [POS_BITS-1:0] NUM_CITIES_RESET = 5'd5;
  localparam logic [POS_BITS-1:0] MIN_CITIES = 5'd3;
  localparam logic [LEN_BITS-1:0] LEN_SAT = 20'hFFFFF;

  localparam logic [1:0] ACT_DIST = 2'd0;
  localparam logic [1:0] ACT_PARENT = 2'd1;
  localparam logic [1:0] ACT_CROSS = 2'd2;
  localparam logic [1:0] ACT_MUTATE = 2'd3;

  typedef struct packed {
    logic [1:0]           action;
    logic [CITY_BITS-1:0] row;
    logic [CITY_BITS-1:0] col;
    logic [DIST_BITS-1:0] distance;
    logic                 no_edge;
    logic                 which_parent;
    logic [CITY_BITS-1:0] position;
    logic [CITY_BITS-1:0] city;
    logic [CITY_BITS-1:0] barrier;
    logic                 swap_ok;
    logic [CITY_BITS-1:0] swap_a;
    logic [CITY_BITS-1:0] swap_b;
  } cmd_t;
endpackage
`default_nettype wire

### rtl/tour_crossover_mutate_evaluate.sv
// Top level of the tour crossover, mutate and evaluate block.
// Input items enter through push/full; an item is taken when push is high and full low.
// Action 0 writes a distance entry, 1 writes a parent city; each is stored as it leaves
// the command queue and gives no result. Action 2 (crossover) and 3
// (mutate) each give n+1 results, one per tour position plus the closing start city;
// the last one carries the length or no_route. Results leave through empty/pop, one per
// cycle while pop is high.
// A crossover walks the parent store with one read per cycle, a mutate reads its parent
// and then writes back the two swapped cities in states MWRA and MWRB; evaluation then
// reads the distance RAM once per edge and streams n + 1 results, paced by the single
// read port of each store. A two-entry command queue lets the next items be accepted
// while a tour is in work.
// num_cities is written on cfg_valid/cfg_ready (always ready); the user must do so only
// while the block is idle, as the block itself does not enforce it.
// A synchronous rst empties the queue and result register and sets num_cities to 5;
// the stores keep their contents. When pop stays low the last result is held and the
// evaluator waits; the queue fills and full rises.
`default_nettype none
module tour_crossover_mutate_evaluate (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tcme_pkg::POS_BITS-1:0]  cfg_data,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic [1:0]                     action,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] row,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] col,
  input  wire logic [tcme_pkg::DIST_BITS-1:0] distance,
  input  wire logic                           no_edge,
  input  wire logic                           which_parent,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] position,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] city,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] barrier,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] swap_a,
  input  wire logic [tcme_pkg::CITY_BITS-1:0] swap_b,
  output logic                                empty,
  input  wire logic                           pop,
  output logic [tcme_pkg::CITY_BITS-1:0]      tour_city,
  output logic [tcme_pkg::POS_BITS-1:0]       tour_position,
  output logic [tcme_pkg::LEN_BITS-1:0]       tour_length,
  output logic                                no_route,
  output logic                                last
);
  logic [tcme_pkg::POS_BITS-1:0] num_cities;
  logic [tcme_pkg::POS_BITS-1:0] n;
  tcme_pkg::cmd_t q_cmd;
  logic q_valid;
  logic q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_cities <= tcme_pkg::NUM_CITIES_RESET;
    end else if (cfg_valid) begin
      num_cities <= cfg_data;
    end
  end

  // saturate into 3 .. MAX_CITIES
  always_comb begin
    if (num_cities < tcme_pkg::MIN_CITIES) begin
      n = tcme_pkg::MIN_CITIES;
    end else if (num_cities > tcme_pkg::POS_BITS'(tcme_pkg::MAX_CITIES)) begin
      n = tcme_pkg::POS_BITS'(tcme_pkg::MAX_CITIES);
    end else begin
      n = num_cities;
    end
  end

  tcme_front u_front (
    .clk(clk), .rst(rst), .n(n), .push(push), .full(full), .action(action),
    .row(row), .col(col), .distance(distance), .no_edge(no_edge),
    .which_parent(which_parent), .position(position), .city(city),
    .barrier(barrier), .swap_a(swap_a), .swap_b(swap_b),
    .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop)
  );

  tcme_back u_back (
    .clk(clk), .rst(rst), .n(n), .q_cmd(q_cmd), .q_valid(q_valid), .q_pop(q_pop),
    .empty(empty), .pop(pop), .tour_city(tour_city), .tour_position(tour_position),
    .tour_length(tour_length), .no_route(no_route), .last(last)
  );
endmodule
`default_nettype wire

### rtl/tcme_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tcme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### rtl/tcme_front.sv
// Front end: accepts items, clamps their fields and queues commands for the back end.
`default_nettype none
module tcme_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [tcme_pkg::POS_BITS-1:0]      n,
  input  wire logic                               push,
  output logic                                    full,
  input  wire logic [1:0]                         action,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     row,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     col,
  input  wire logic [tcme_pkg::DIST_BITS-1:0]     distance,
  input  wire logic                               no_edge,
  input  wire logic                               which_parent,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     position,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     city,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     barrier,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     swap_a,
  input  wire logic [tcme_pkg::CITY_BITS-1:0]     swap_b,
  output tcme_pkg::cmd_t                          q_cmd,
  output logic                                    q_valid,
  input  wire logic                               q_pop
);
  tcme_pkg::cmd_t cmd;
  tcme_pkg::cmd_t slot [2];
  logic wptr;
  logic rptr;
  logic [1:0] count;
  logic [tcme_pkg::POS_BITS-1:0] bar_wide;
  logic [tcme_pkg::POS_BITS-1:0] a_wide;
  logic [tcme_pkg::POS_BITS-1:0] b_wide;
  logic do_push;
  logic do_pop;

  always_comb begin
    bar_wide = {1'b0, barrier};
    a_wide = {1'b0, swap_a};
    b_wide = {1'b0, swap_b};
    // clamp barrier into 1 .. n-1
    if (bar_wide == '0) begin
      bar_wide = 5'd1;
    end else if (bar_wide > n - 5'd1) begin
      bar_wide = n - 5'd1;
    end
    cmd.action = action;
    cmd.row = row;
    cmd.col = col;
    cmd.distance = distance;
    cmd.no_edge = no_edge;
    cmd.which_parent = which_parent;
    cmd.position = position;
    cmd.city = city;
    cmd.barrier = bar_wide[tcme_pkg::CITY_BITS-1:0];
    cmd.swap_ok = (swap_a != '0) && (a_wide < n) && (swap_b != '0) && (b_wide < n)
                  && (swap_a != swap_b);
    cmd.swap_a = swap_a;
    cmd.swap_b = swap_b;
  end

  assign full = count[1];
  assign q_valid = count != 2'd0;
  assign q_cmd = slot[rptr];
  assign do_push = push && !full;
  assign do_pop = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wptr] <= cmd;
    end
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_push) begin
        wptr <= !wptr;
      end
      if (do_pop) begin
        rptr <= !rptr;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("command queue count out of range");
  assert property (@(posedge clk) disable iff (rst) (do_push && !do_pop) |=> count != 2'd0)
    else $error("pushed command lost");
  assert property (@(posedge clk) disable iff (rst) (count == 2'd0) |-> !do_pop)
    else $error("pop from empty command queue");
endmodule
`default_nettype wire

### rtl/tcme_back.sv
// Back end: stores, crossover and mutation sequencer, tour evaluation and result register.
`default_nettype none
module tcme_back (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic [tcme_pkg::POS_BITS-1:0]      n,
  input  wire tcme_pkg::cmd_t                     q_cmd,
  input  wire logic                               q_valid,
  output logic                                    q_pop,
  output logic                                    empty,
  input  wire logic                               pop,
  output logic [tcme_pkg::CITY_BITS-1:0]          tour_city,
  output logic [tcme_pkg::POS_BITS-1:0]           tour_position,
  output logic [tcme_pkg::LEN_BITS-1:0]           tour_length,
  output logic                                    no_route,
  output logic                                    last
);
  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_XO = 4'd1;
  localparam logic [3:0] ST_MLOAD = 4'd2;
  localparam logic [3:0] ST_MWRA = 4'd3;
  localparam logic [3:0] ST_MWRB = 4'd4;
  localparam logic [3:0] ST_CLOSE = 4'd5;
  localparam logic [3:0] ST_SUM = 4'd6;
  localparam logic [3:0] ST_FLUSH = 4'd7;
  localparam logic [3:0] ST_EMIT = 4'd8;

  localparam logic [1:0] PH_HEAD = 2'd0;
  localparam logic [1:0] PH_MOM = 2'd1;
  localparam logic [1:0] PH_TAIL = 2'd2;

  localparam int CB = tcme_pkg::CITY_BITS;
  localparam int PB = tcme_pkg::POS_BITS;

  logic [3:0] state;
  logic [1:0] phase;
  logic which;
  logic [CB-1:0] bar;
  logic swap_ok;
  logic [CB-1:0] sa;
  logic [CB-1:0] sb;
  logic [PB-1:0] pos;
  logic iss_done;
  logic rd_vld;
  logic rd_cond;
  logic [CB-1:0] rd_pos;
  logic [CB-1:0] wt [tcme_pkg::MAX_CITIES + 1];
  logic [PB-1:0] len;
  logic [tcme_pkg::MAX_CITIES-1:0] used;
  logic [PB-1:0] idx;
  logic [CB-1:0] prev;
  logic dvld;
  logic [tcme_pkg::LEN_BITS-1:0] sum;
  logic miss;
  logic ovalid;

  logic p_we;
  logic [tcme_pkg::PADDR_BITS-1:0] p_addr;
  logic [CB-1:0] p_wdata;
  logic [CB-1:0] p_rdata;
  logic d_we;
  logic [tcme_pkg::DADDR_BITS-1:0] d_addr;
  logic [tcme_pkg::DIST_BITS:0] d_rdata;
  logic [PB-1:0] wt_idx;
  logic [CB-1:0] wt_rd;
  logic [CB-1:0] pos_eff;
  logic sel;
  logic take;
  logic [CB-1:0] mpos;
  logic [tcme_pkg::LEN_BITS:0] sum_add;
  logic free;
  logic emit;

  always_comb begin
    pos_eff = (pos == n) ? '0 : pos[CB-1:0];
    sel = (state == ST_XO && phase == PH_MOM) ? !which : which;
    unique case (state)
      ST_MWRA: wt_idx = {1'b0, sa};
      ST_MWRB: wt_idx = {1'b0, sb};
      ST_SUM:  wt_idx = idx + 5'd1;
      default: wt_idx = idx;
    endcase
    wt_rd = wt[wt_idx];
    p_we = 1'b0;
    p_wdata = wt_rd;
    priority case (state)
      ST_IDLE: begin
        p_addr = {q_cmd.which_parent, q_cmd.position};
        p_we = q_valid && q_cmd.action == tcme_pkg::ACT_PARENT;
        p_wdata = q_cmd.city;
      end
      ST_MWRA: begin
        p_addr = {which, sa};
        p_we = swap_ok;
      end
      ST_MWRB: begin
        p_addr = {which, sb};
        p_we = swap_ok;
      end
      default: p_addr = {sel, pos_eff};
    endcase
    d_we = state == ST_IDLE && q_valid && q_cmd.action == tcme_pkg::ACT_DIST;
    d_addr = (state == ST_IDLE) ? {q_cmd.row, q_cmd.col} : {prev, wt_rd};
    take = !rd_cond || (len < n && !used[p_rdata]);
    if (swap_ok && rd_pos == sa) begin
      mpos = sb;
    end else if (swap_ok && rd_pos == sb) begin
      mpos = sa;
    end else begin
      mpos = rd_pos;
    end
    sum_add = {1'b0, sum} + {{(tcme_pkg::LEN_BITS + 1 - tcme_pkg::DIST_BITS){1'b0}},
                             d_rdata[tcme_pkg::DIST_BITS-1:0]};
  end

  assign q_pop = state == ST_IDLE && q_valid;
  assign free = !ovalid || pop;
  assign emit = state == ST_EMIT && free;
  assign empty = !ovalid;

  tcme_ram #(.WIDTH(CB), .DEPTH(2 * tcme_pkg::MAX_CITIES)) u_parent (
    .clk(clk), .we(p_we), .waddr(p_addr), .wdata(p_wdata), .raddr(p_addr),
    .rdata(p_rdata)
  );

  tcme_ram #(.WIDTH(tcme_pkg::DIST_BITS + 1),
             .DEPTH(tcme_pkg::MAX_CITIES * tcme_pkg::MAX_CITIES)) u_dist (
    .clk(clk), .we(d_we), .waddr(d_addr), .wdata({q_cmd.no_edge, q_cmd.distance}),
    .raddr(d_addr), .rdata(d_rdata)
  );

  always_ff @(posedge clk) begin
    // absorb parent city read issued last cycle
    if (rd_vld && state == ST_XO && take) begin
      wt[len] <= p_rdata;
      used[p_rdata] <= 1'b1;
      len <= len + 5'd1;
    end
    if (rd_vld && state == ST_MLOAD) begin
      wt[{1'b0, mpos}] <= p_rdata;
    end
    if (dvld) begin
      if (d_rdata[tcme_pkg::DIST_BITS]) begin
        miss <= 1'b1;
      end else begin
        sum <= sum_add[tcme_pkg::LEN_BITS] ? tcme_pkg::LEN_SAT
                                           : sum_add[tcme_pkg::LEN_BITS-1:0];
      end
    end
    if (emit) begin
      tour_city <= wt_rd;
      tour_position <= idx;
      tour_length <= (idx == len && !miss) ? sum : '0;
      no_route <= idx == len && miss;
      last <= idx == len;
    end
    unique case (state)
      ST_IDLE: begin
        which <= q_cmd.which_parent;
        bar <= q_cmd.barrier;
        swap_ok <= q_cmd.swap_ok && q_cmd.action == tcme_pkg::ACT_MUTATE;
        sa <= q_cmd.swap_a;
        sb <= q_cmd.swap_b;
        pos <= '0;
        phase <= PH_HEAD;
        len <= (q_cmd.action == tcme_pkg::ACT_MUTATE) ? n : '0;
        used <= '0;
      end
      ST_XO: begin
        rd_pos <= pos[CB-1:0];
        rd_cond <= phase != PH_HEAD;
        unique case (phase)
          PH_HEAD: begin
            if (pos + 5'd1 == {1'b0, bar}) begin
              phase <= PH_MOM;
              pos <= {1'b0, bar} + 5'd1;
            end else begin
              pos <= pos + 5'd1;
            end
          end
          PH_MOM: begin
            if (pos == n) begin
              phase <= PH_TAIL;
              pos <= {1'b0, bar};
            end else begin
              pos <= pos + 5'd1;
            end
          end
          default: pos <= pos + 5'd1;
        endcase
      end
      ST_MLOAD: begin
        rd_pos <= pos[CB-1:0];
        pos <= pos + 5'd1;
      end
      ST_CLOSE: begin
        wt[len] <= wt[0];
        prev <= wt[0];
        idx <= '0;
        sum <= '0;
        miss <= 1'b0;
      end
      ST_SUM: begin
        prev <= wt_rd;
        idx <= (idx == len - 5'd1) ? '0 : idx + 5'd1;
      end
      ST_EMIT: begin
        if (emit) begin
          idx <= idx + 5'd1;
        end
      end
      default: begin
      end
    endcase
    if (rst) begin
      state <= ST_IDLE;
      rd_vld <= 1'b0;
      iss_done <= 1'b0;
      dvld <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      dvld <= state == ST_SUM;
      if (emit) begin
        ovalid <= 1'b1;
      end else if (pop) begin
        ovalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          iss_done <= 1'b0;
          rd_vld <= 1'b0;
          if (q_valid && q_cmd.action == tcme_pkg::ACT_CROSS) begin
            state <= ST_XO;
          end else if (q_valid && q_cmd.action == tcme_pkg::ACT_MUTATE) begin
            state <= ST_MLOAD;
          end
        end
        ST_XO: begin
          if (iss_done) begin
            rd_vld <= 1'b0;
            state <= ST_CLOSE;
          end else begin
            rd_vld <= 1'b1;
            if (phase == PH_TAIL && pos == n) begin
              iss_done <= 1'b1;
            end
          end
        end
        ST_MLOAD: begin
          if (iss_done) begin
            rd_vld <= 1'b0;
            state <= ST_MWRA;
          end else begin
            rd_vld <= 1'b1;
            if (pos == n - 5'd1) begin
              iss_done <= 1'b1;
            end
          end
        end
        ST_MWRA: state <= ST_MWRB;
        ST_MWRB: state <= ST_CLOSE;
        ST_CLOSE: state <= ST_SUM;
        ST_SUM: begin
          if (idx == len - 5'd1) begin
            state <= ST_FLUSH;
          end
        end
        ST_FLUSH: state <= ST_EMIT;
        ST_EMIT: begin
          if (emit && idx == len) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state != ST_IDLE) |-> len <= n)
    else $error("child tour longer than city count");
  assert property (@(posedge clk) disable iff (rst) (state == ST_IDLE) |-> !rd_vld && !dvld)
    else $error("store read pending while idle");
  assert property (@(posedge clk) disable iff (rst)
                   (emit && idx == len) |=> (ovalid && last && state == ST_IDLE))
    else $error("closing result not marked last");
endmodule
`default_nettype wire
